>>> hdl/assert_macros.svh
// Assertion macros shared by the cache max-age parser modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, disabled while in reset.
`define CMAFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check an implication that starts from a trigger condition.
`define CMAFP_ASSERT_IMPL(lbl, trig, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (trig) |-> (prop)) \
    else $error(msg);

`endif

>>> hdl/cmafp_pkg.sv
// Types, constants and helper functions of the cache max-age parser.
`timescale 1ns / 1ps

package cmafp_pkg;

  // Register reset values
  localparam logic [31:0] FALLBACK_RESET = 32'd3600;
  localparam logic [31:0] MIN_RESET      = 32'd60;
  localparam logic [31:0] MAX_RESET      = 32'd86400;

  // Token and blank characters
  localparam logic [3:0] TOKEN_LEN  = 4'd8;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;
  localparam logic [7:0] CHAR_M     = 8'h6d;

  // Configuration register indexes
  typedef enum logic [1:0] {
    CFG_FALLBACK = 2'd0,
    CFG_MIN      = 2'd1,
    CFG_MAX      = 2'd2
  } cfg_idx_e;

  // Parse phases
  typedef enum logic [2:0] {
    PH_SEARCH = 3'd0,
    PH_BLANKS = 3'd1,
    PH_DIGITS = 3'd2,
    PH_NUMBER = 3'd3,
    PH_NONE   = 3'd4
  } phase_e;

  typedef struct packed {
    logic [31:0] fallback_seconds;
    logic [31:0] min_seconds;
    logic [31:0] max_seconds;
  } cfg_t;

  typedef struct packed {
    logic [31:0] age_seconds;
    logic        from_header;
  } result_t;

  // Character of "max-age=" at a given position
  function automatic logic [7:0] token_char(input logic [2:0] idx);
    logic [7:0] ch;
    unique case (idx)
      3'd0:    ch = 8'h6d; // m
      3'd1:    ch = 8'h61; // a
      3'd2:    ch = 8'h78; // x
      3'd3:    ch = 8'h2d; // -
      3'd4:    ch = 8'h61; // a
      3'd5:    ch = 8'h67; // g
      3'd6:    ch = 8'h65; // e
      default: ch = 8'h3d; // =
    endcase
    return ch;
  endfunction

  // Fold upper-case ASCII letters to lower case
  function automatic logic [7:0] fold_lower(input logic [7:0] c);
    logic [7:0] r;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r = c | 8'h20;
    end else begin
      r = c;
    end
    return r;
  endfunction

endpackage

>>> hdl/cache_max_age_field_parser.sv
// Top level of the cache max-age parser: input stage, parser and result register.
//
// One header character is accepted per clock when the output side keeps up.
// A character enters an input register, the parser folds it into its state in
// the next cycle (token match, multiply-by-ten add and clamp compare in one
// pass), and the character marked last loads the result register. A waiting
// result blocks the stage only when the next final character arrives; other
// characters keep flowing. Configuration writes are taken in every cycle.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cache_max_age_field_parser import cmafp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [7:0]  char_code_i,
  input  logic        char_valid_i,
  input  logic        is_last_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] age_seconds_o,
  output logic        from_header_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i
);

  cfg_t    cfg;
  result_t result;

  logic       in_vld_q, in_vld_d;
  logic [7:0] char_code_q;
  logic       char_valid_q;
  logic       is_last_q;
  logic       out_vld_q, out_vld_d;
  result_t    out_res_q;
  logic       adv;

  assign cfg_ready_o = 1'b1;

  cmafp_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Advance the staged character unless its result has nowhere to go
  assign adv        = in_vld_q && (!is_last_q || !out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || adv;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_ready_o) begin
      in_vld_d = in_valid_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else begin
      in_vld_q <= in_vld_d;
    end
  end

  // Capture the input transaction payload
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      char_code_q  <= char_code_i;
      char_valid_q <= char_valid_i;
      is_last_q    <= is_last_i;
    end
  end

  cmafp_parse u_parse (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .adv_i        (adv),
    .char_code_i  (char_code_q),
    .char_valid_i (char_valid_q),
    .is_last_i    (is_last_q),
    .cfg_i        (cfg),
    .result_o     (result)
  );

  // Result register: load on a final character, drop once taken
  always_comb begin
    out_vld_d = out_vld_q;
    if (out_ready_i) begin
      out_vld_d = 1'b0;
    end
    if (adv && is_last_q) begin
      out_vld_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv && is_last_q) begin
      out_res_q <= result;
    end
  end

  assign out_valid_o   = out_vld_q;
  assign age_seconds_o = out_res_q.age_seconds;
  assign from_header_o = out_res_q.from_header;

  // A final character facing a stalled result must hold the input side
  `CMAFP_ASSERT_IMPL(a_stall_blocks, in_vld_q && is_last_q && out_vld_q && !out_ready_i, !in_ready_o && !adv, "final character advanced over a stalled result")
  // A new result only follows a final character leaving the stage
  `CMAFP_ASSERT(a_result_source, $rose(out_vld_q) |-> $past(adv && is_last_q), "result raised without a final character")

endmodule

>>> hdl/cmafp_cfg_regs.sv
// Configuration register file: fallback, minimum and maximum age.
`timescale 1ns / 1ps

module cmafp_cfg_regs import cmafp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [31:0] cfg_data_i,
  output cfg_t        cfg_o
);

  cfg_t cfg_q, cfg_d;

  // Decode the write transaction; unknown indexes leave everything alone
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FALLBACK: cfg_d.fallback_seconds = cfg_data_i;
        CFG_MIN:      cfg_d.min_seconds      = cfg_data_i;
        CFG_MAX:      cfg_d.max_seconds      = cfg_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.fallback_seconds <= FALLBACK_RESET;
      cfg_q.min_seconds      <= MIN_RESET;
      cfg_q.max_seconds      <= MAX_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

>>> hdl/cmafp_parse.sv
// Per-character parse state machine and result computation.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module cmafp_parse import cmafp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        adv_i,
  input  logic [7:0]  char_code_i,
  input  logic        char_valid_i,
  input  logic        is_last_i,
  input  cfg_t        cfg_i,
  output result_t     result_o
);

  phase_e      phase_q, phase_d, phase_c;
  logic [3:0]  matched_q, matched_d, matched_c;
  logic [31:0] num_q, num_d, num_c;

  logic [7:0]  lc;
  logic        is_digit;
  logic        is_blank;
  logic [35:0] acc;
  logic        sat;

  // Classify the character and form the next accumulated value
  always_comb begin
    lc       = fold_lower(char_code_i);
    is_digit = (lc >= 8'h30) && (lc <= 8'h39);
    is_blank = (lc == CHAR_SPACE) || (lc == CHAR_TAB);
    acc      = ({4'd0, num_q} << 3) + ({4'd0, num_q} << 1) + {32'd0, lc[3:0]};
    sat      = acc > {4'd0, cfg_i.max_seconds};
  end

  // Next state after this character
  always_comb begin
    phase_c   = phase_q;
    matched_c = matched_q;
    num_c     = num_q;
    if (char_valid_i) begin
      unique case (phase_q)
        PH_SEARCH: begin
          if (lc == token_char(matched_q[2:0])) begin
            matched_c = matched_q + 4'd1;
          end else begin
            matched_c = (lc == CHAR_M) ? 4'd1 : 4'd0;
          end
          if (matched_c == TOKEN_LEN) begin
            phase_c = PH_BLANKS;
          end
        end
        PH_BLANKS, PH_DIGITS: begin
          if (phase_q == PH_BLANKS && is_blank) begin
            phase_c = PH_BLANKS;
          end else if (!is_digit) begin
            phase_c = (phase_q == PH_BLANKS) ? PH_NONE : PH_NUMBER;
          end else if (sat) begin
            num_c   = cfg_i.max_seconds;
            phase_c = PH_NUMBER;
          end else begin
            num_c   = acc[31:0];
            phase_c = PH_DIGITS;
          end
        end
        default: phase_c = phase_q;
      endcase
    end
  end

  // Hold, advance, or clear at the end of a header
  always_comb begin
    phase_d   = phase_q;
    matched_d = matched_q;
    num_d     = num_q;
    if (adv_i) begin
      if (is_last_i) begin
        phase_d   = PH_SEARCH;
        matched_d = 4'd0;
        num_d     = 32'd0;
      end else begin
        phase_d   = phase_c;
        matched_d = matched_c;
        num_d     = num_c;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_SEARCH;
      matched_q <= 4'd0;
      num_q     <= 32'd0;
    end else begin
      phase_q   <= phase_d;
      matched_q <= matched_d;
      num_q     <= num_d;
    end
  end

  // Result from the state after this character
  always_comb begin
    if (phase_c == PH_DIGITS || phase_c == PH_NUMBER) begin
      result_o.age_seconds = (num_c < cfg_i.min_seconds) ? cfg_i.min_seconds : num_c;
      result_o.from_header = 1'b1;
    end else begin
      result_o.age_seconds = cfg_i.fallback_seconds;
      result_o.from_header = 1'b0;
    end
  end

  // A finished header leaves the parser in its initial state
  `CMAFP_ASSERT(a_clear_after_last, (adv_i && is_last_i) |=> (phase_q == PH_SEARCH && matched_q == 4'd0 && num_q == 32'd0), "state not cleared after last character")
  // While searching, the match count never reaches the full token
  `CMAFP_ASSERT_IMPL(a_search_count, phase_q == PH_SEARCH, matched_q < TOKEN_LEN, "match count out of range during search")

endmodule
